>>> design/tccg_pkg.sv
// ----------------------------------------------------------------------------
// tccg_pkg
// Shared types and constants for the text console character grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tccg_pkg;

	localparam int DEF_ROWS = 24;
	localparam int DEF_COLS = 80;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_DEL   = 8'd127;

	localparam logic [15:0] BLINK_RESET = 16'd50;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_byte;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} req_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic       cursor_visible;
		logic       blink_toggled;
		logic       scrolled;
	} rsp_t;

	typedef struct packed {
		logic wr;
		logic blank;
		logic clear;
		logic rd;
	} store_ctl_t;

endpackage

`default_nettype wire

>>> design/text_console_char_grid.sv
// ----------------------------------------------------------------------------
// text_console_char_grid
// Text console: character grid kept as a ring of rows, cursor and blink phase.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  req      in         req_valid / req_stall   req_data  (req_t)
//  rsp      out        rsp_valid / rsp_stall   rsp_data  (rsp_t)
//  cfg      in         cfg_valid / cfg_ready   cfg_data  (blink period)
//
//  A request passes the states IDLE, EXEC and FIN; its response is loaded in
//  FIN, and a new request is accepted only once the block is back in IDLE.
//  A cell read adds RDWAIT, for the read latency of the character memory.
//  Reset clears the per-row fill counts, so every cell reads as empty at once.
//  The response register lets a new request enter while a response is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_grid
	import tccg_pkg::*;
#(
	parameter int SCREEN_ROWS = DEF_ROWS,
	parameter int SCREEN_COLS = DEF_COLS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_t        req_data,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_t             rsp_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int RSUM_W = ROW_W + 1;
	localparam int COL_W  = $clog2(SCREEN_COLS + 1);
	localparam int CIDX_W = $clog2(SCREEN_COLS);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_RDWAIT = 2'd2;
	localparam logic [1:0] ST_FIN    = 2'd3;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [COL_W-1:0] WRAP_COL = COL_W'(SCREEN_COLS);

	logic [1:0]        st_q;
	req_t              req_q;
	logic [ROW_W-1:0]  top_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic              vis_q;
	logic [15:0]       tick_q;
	logic [15:0]       period_q;
	logic [7:0]        cell_q;
	logic              tog_q;
	logic              scr_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [ROW_W-1:0]  nl_top;
	logic [ROW_W-1:0]  nl_row;
	logic              nl_scr;
	logic [ROW_W-1:0]  top_d;
	logic [ROW_W-1:0]  row_d;
	logic [COL_W-1:0]  col_d;
	logic              vis_d;
	logic [15:0]       tick_d;
	logic              tog_d;
	logic              scr_d;
	store_ctl_t        ctl_d;
	store_ctl_t        store_ctl;
	logic [ROW_W-1:0]  s_row;
	logic [CIDX_W-1:0] s_col;
	logic [7:0]        s_data;
	logic [7:0]        s_rdata;
	logic              rsp_load;

	function automatic logic [ROW_W-1:0] phys(input logic [ROW_W-1:0] base,
			input logic [ROW_W-1:0] r);
		logic [RSUM_W-1:0] s;
		s = {1'b0, base} + {1'b0, r};
		if (s >= RSUM_W'(SCREEN_ROWS)) begin
			s = s - RSUM_W'(SCREEN_ROWS);
		end
		return s[ROW_W-1:0];
	endfunction

	always_comb begin
		nl_top = top_q;
		nl_row = cur_row_q + ROW_W'(1);
		nl_scr = 1'b0;
		if (cur_row_q == LAST_ROW) begin
			nl_top = (top_q == LAST_ROW) ? '0 : top_q + ROW_W'(1);
			nl_row = LAST_ROW;
			nl_scr = 1'b1;
		end
	end

	always_comb begin
		top_d  = top_q;
		row_d  = cur_row_q;
		col_d  = cur_col_q;
		vis_d  = vis_q;
		tick_d = tick_q;
		tog_d  = 1'b0;
		scr_d  = 1'b0;
		ctl_d  = '0;
		s_row  = phys(top_q, cur_row_q);
		s_col  = '0;
		s_data = 8'h00;
		case (req_q.cmd)
			CMD_PUT: begin
				if (req_q.char_byte inside {CH_LF, CH_CR}) begin
					top_d       = nl_top;
					row_d       = nl_row;
					col_d       = '0;
					scr_d       = nl_scr;
					ctl_d.blank = 1'b1;
					s_row       = phys(nl_top, nl_row);
				end else if (req_q.char_byte == CH_BS) begin
					if (cur_col_q != '0) begin
						col_d    = cur_col_q - COL_W'(1);
						ctl_d.wr = 1'b1;
						s_col    = CIDX_W'(cur_col_q - COL_W'(1));
					end
				end else if (req_q.char_byte inside {[CH_SPACE:CH_DEL]}) begin
					ctl_d.wr = 1'b1;
					s_data   = req_q.char_byte;
					if (cur_col_q >= WRAP_COL) begin
						top_d       = nl_top;
						row_d       = nl_row;
						col_d       = COL_W'(1);
						scr_d       = nl_scr;
						ctl_d.blank = 1'b1;
						s_row       = phys(nl_top, nl_row);
					end else begin
						col_d = cur_col_q + COL_W'(1);
						s_col = CIDX_W'(cur_col_q);
					end
				end
			end
			CMD_CLEAR: begin
				ctl_d.clear = 1'b1;
				top_d       = '0;
				row_d       = '0;
				col_d       = '0;
			end
			CMD_TICK: begin
				if ({1'b0, tick_q} + 17'd1 >= {1'b0, period_q}) begin
					tick_d = '0;
					vis_d  = ~vis_q;
					tog_d  = 1'b1;
				end else begin
					tick_d = tick_q + 16'd1;
				end
			end
			CMD_READ: begin
				if (int'(req_q.read_row) < SCREEN_ROWS
						&& int'(req_q.read_col) < SCREEN_COLS) begin
					ctl_d.rd = 1'b1;
					s_row    = phys(top_q, ROW_W'(req_q.read_row));
					s_col    = CIDX_W'(req_q.read_col);
				end
			end
			default: begin
			end
		endcase
	end

	assign store_ctl = (st_q == ST_EXEC) ? ctl_d : '0;

	tccg_cell_store #(
		.SCREEN_ROWS(SCREEN_ROWS),
		.SCREEN_COLS(SCREEN_COLS)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (store_ctl),
		.row   (s_row),
		.col   (s_col),
		.wdata (s_data),
		.rdata (s_rdata)
	);

	assign rsp_load = (st_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			top_q       <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			vis_q       <= 1'b1;
			tick_q      <= '0;
			period_q    <= BLINK_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				period_q <= cfg_data;
			end
			case (st_q)
				ST_IDLE: begin
					if (req_valid) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					top_q     <= top_d;
					cur_row_q <= row_d;
					cur_col_q <= col_d;
					vis_q     <= vis_d;
					tick_q    <= tick_d;
					st_q      <= ctl_d.rd ? ST_RDWAIT : ST_FIN;
				end
				ST_RDWAIT: begin
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && req_valid) begin
			req_q <= req_data;
		end
		if (st_q == ST_EXEC) begin
			cell_q <= 8'h00;
			tog_q  <= tog_d;
			scr_q  <= scr_d;
		end
		if (st_q == ST_RDWAIT) begin
			cell_q <= s_rdata;
		end
		if (rsp_load) begin
			rsp_q.cell_char      <= cell_q;
			rsp_q.cursor_row     <= 5'(cur_row_q);
			rsp_q.cursor_col     <= 7'(cur_col_q);
			rsp_q.cursor_visible <= vis_q;
			rsp_q.blink_toggled  <= tog_q;
			rsp_q.scrolled       <= scr_q;
		end
	end

	assign req_stall = (st_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign cfg_ready = 1'b1;

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(st_q) == ST_FIN)
		else $error("Response raised outside the finishing state.");

	a_rdwait_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RDWAIT |-> $past(st_q) == ST_EXEC && $past(req_q.cmd) == CMD_READ)
		else $error("Read wait entered without a cell read request.");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q <= WRAP_COL && cur_row_q <= LAST_ROW && top_q <= LAST_ROW)
		else $error("Cursor or top row offset out of range.");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_EXEC |=> $stable(cur_row_q) && $stable(cur_col_q) && $stable(top_q))
		else $error("Cursor changed outside the execute state.");

endmodule

`default_nettype wire

>>> design/tccg_cell_store.sv
// ----------------------------------------------------------------------------
// tccg_cell_store
// Character memory with a fill count per physical row; cells at or beyond a
// row's fill count read as empty, so blanking a row or the grid is immediate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccg_cell_store
	import tccg_pkg::*;
#(
	parameter int SCREEN_ROWS = DEF_ROWS,
	parameter int SCREEN_COLS = DEF_COLS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire store_ctl_t                     ctl,
	input  wire logic [$clog2(SCREEN_ROWS)-1:0] row,
	input  wire logic [$clog2(SCREEN_COLS)-1:0] col,
	input  wire logic [7:0]                     wdata,
	output logic [7:0]                          rdata
);

	localparam int CNT_W  = $clog2(SCREEN_COLS + 1);
	localparam int DEPTH  = SCREEN_ROWS * SCREEN_COLS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [7:0]        mem [DEPTH];
	logic [CNT_W-1:0]  fill_q [SCREEN_ROWS];
	logic [ADDR_W-1:0] addr;
	logic [CNT_W-1:0]  col_cnt;
	logic [CNT_W-1:0]  row_fill;
	logic [7:0]        rdat_q;
	logic              hit_q;

	assign addr     = ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(col);
	assign col_cnt  = CNT_W'(col);
	assign row_fill = fill_q[row];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SCREEN_ROWS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			for (int i = 0; i < SCREEN_ROWS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (ctl.wr && (ctl.blank || col_cnt >= row_fill)) begin
				fill_q[row] <= CNT_W'(col_cnt + CNT_W'(1));
			end else if (ctl.blank) begin
				fill_q[row] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdat_q <= mem[addr];
			hit_q  <= col_cnt < row_fill;
		end
	end

	assign rdata = hit_q ? rdat_q : 8'h00;

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the text console character grid. Requests are driven
// through the stall handshake and a shadow model of the grid, cursor and blink
// phase predicts every response, which is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import tccg_pkg::*;

	localparam int ROWS = DEF_ROWS;
	localparam int COLS = DEF_COLS;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	logic [7:0]  grid [0:ROWS-1][0:COLS-1];
	int          top_row;
	int          cur_row;
	int          cur_col;
	logic        visible;
	int          tick_count;
	int          blink_period;

	rsp_t        expected_rsp [$];
	int          mismatches = 0;
	int          requests_sent = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_left = 0;

	text_console_char_grid u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("FAIL text_console_char_grid");
		$finish;
	end

	function automatic bit advance_line();
		bit scroll;
		scroll = 1'b0;
		cur_col = 0;
		if (cur_row + 1 >= ROWS) begin
			top_row = (top_row + 1) % ROWS;
			scroll = 1'b1;
		end else begin
			cur_row++;
		end
		for (int c = 0; c < COLS; c++)
			grid[(top_row + cur_row) % ROWS][c] = 8'd0;
		return scroll;
	endfunction

	function automatic rsp_t predict_console(req_t r);
		rsp_t o;
		o = '0;
		case (r.cmd)
			CMD_PUT: begin
				if (r.char_byte == CH_LF || r.char_byte == CH_CR) begin
					o.scrolled = advance_line();
				end else if (r.char_byte == CH_BS) begin
					if (cur_col > 0) begin
						cur_col--;
						grid[(top_row + cur_row) % ROWS][cur_col] = 8'd0;
					end
				end else if (r.char_byte >= CH_SPACE && r.char_byte <= CH_DEL) begin
					if (cur_col >= COLS)
						o.scrolled = advance_line();
					grid[(top_row + cur_row) % ROWS][cur_col] = r.char_byte;
					cur_col++;
				end
			end
			CMD_CLEAR: begin
				for (int rr = 0; rr < ROWS; rr++)
					for (int c = 0; c < COLS; c++)
						grid[rr][c] = 8'd0;
				top_row = 0;
				cur_row = 0;
				cur_col = 0;
			end
			CMD_TICK: begin
				if (tick_count + 1 >= blink_period) begin
					tick_count = 0;
					visible = ~visible;
					o.blink_toggled = 1'b1;
				end else begin
					tick_count = (tick_count + 1) & 16'hFFFF;
				end
			end
			CMD_READ: begin
				if (r.read_row < ROWS && r.read_col < COLS)
					o.cell_char = grid[(top_row + r.read_row) % ROWS][r.read_col];
			end
			default: begin
			end
		endcase
		o.cursor_row = 5'(cur_row);
		o.cursor_col = 7'(cur_col);
		o.cursor_visible = visible;
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_request(logic [1:0] cmd, logic [7:0] b, logic [4:0] rr, logic [6:0] rc);
		req_t r;
		r = '{cmd: cmd, char_byte: b, read_row: rr, read_col: rc};
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		expected_rsp.push_back(predict_console(r));
		if (!(cmd == CMD_PUT && b != CH_BS && b != CH_LF && b != CH_CR
				&& (b < CH_SPACE || b > CH_DEL)))
			requests_sent++;
	endtask

	task automatic put_char(logic [7:0] b);
		send_request(CMD_PUT, b, 5'($urandom), 7'($urandom));
	endtask

	task automatic read_cell(logic [4:0] rr, logic [6:0] rc);
		send_request(CMD_READ, 8'($urandom), rr, rc);
	endtask

	task automatic send_plain(logic [1:0] cmd);
		send_request(cmd, 8'($urandom), 5'($urandom), 7'($urandom));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_blink_period(logic [15:0] period);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= period;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		blink_period = period;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("response with no request outstanding", 0, 0);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp_data.cell_char !== want.cell_char)
					report_mismatch("cell_char", rsp_data.cell_char, want.cell_char);
				if (rsp_data.cursor_row !== want.cursor_row)
					report_mismatch("cursor_row", rsp_data.cursor_row, want.cursor_row);
				if (rsp_data.cursor_col !== want.cursor_col)
					report_mismatch("cursor_col", rsp_data.cursor_col, want.cursor_col);
				if (rsp_data.cursor_visible !== want.cursor_visible)
					report_mismatch("cursor_visible", rsp_data.cursor_visible,
						want.cursor_visible);
				if (rsp_data.blink_toggled !== want.blink_toggled)
					report_mismatch("blink_toggled", rsp_data.blink_toggled,
						want.blink_toggled);
				if (rsp_data.scrolled !== want.scrolled)
					report_mismatch("scrolled", rsp_data.scrolled, want.scrolled);
			end
		end
	end

	task automatic test_bytes_and_reads();
		read_cell(5'd0, 7'd0);
		read_cell(5'd23, 7'd79);
		read_cell(5'd24, 7'd0);
		read_cell(5'd31, 7'd127);
		read_cell(5'd0, 7'd80);
		put_char(CH_BS);
		put_char(8'd0);
		put_char(8'd31);
		put_char(8'd128);
		put_char(8'd255);
		put_char(CH_SPACE);
		put_char(CH_DEL);
		put_char(8'd65);
		read_cell(5'd0, 7'd0);
		read_cell(5'd0, 7'd1);
		read_cell(5'd0, 7'd2);
		put_char(CH_BS);
		read_cell(5'd0, 7'd2);
		put_char(CH_CR);
		put_char(CH_LF);
		put_char(8'd90);
		send_plain(CMD_TICK);
		send_plain(CMD_CLEAR);
		read_cell(5'd0, 7'd0);
		wait_drained();
	endtask

	task automatic test_blink_period();
		logic [15:0] periods [5] = '{16'd0, 16'd1, 16'd3, 16'd65535, 16'd2};
		foreach (periods[i]) begin
			write_blink_period(periods[i]);
			repeat (5) send_plain(CMD_TICK);
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 300;
		repeat (40)
			put_char(8'($urandom_range(32, 127)));
		wait_drained();
	endtask

	task automatic test_random_traffic(int n, int idle_pct, int stall, logic [15:0] period);
		int target;
		int kind;
		write_blink_period(period);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		target = requests_sent + n;
		while (requests_sent < target) begin
			kind = $urandom_range(99);
			if (kind < 6) begin
				while (cur_col < COLS)
					put_char(8'($urandom_range(32, 127)));
				put_char(CH_BS);
				put_char(8'($urandom_range(32, 127)));
			end else if (kind < 40) begin
				repeat ($urandom_range(1, 30))
					put_char(8'($urandom_range(32, 127)));
			end else if (kind < 52) begin
				put_char($urandom_range(1) ? CH_LF : CH_CR);
			end else if (kind < 60) begin
				put_char(CH_BS);
			end else if (kind < 72) begin
				send_plain(CMD_TICK);
			end else if (kind < 92) begin
				if ($urandom_range(7) == 0)
					read_cell(5'($urandom), 7'($urandom));
				else
					read_cell(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
			end else if (kind < 99) begin
				put_char(8'($urandom));
			end else if ($urandom_range(3) == 0) begin
				send_plain(CMD_CLEAR);
			end
		end
		wait_drained();
	endtask

	initial begin
		for (int rr = 0; rr < ROWS; rr++)
			for (int c = 0; c < COLS; c++)
				grid[rr][c] = 8'd0;
		top_row = 0;
		cur_row = 0;
		cur_col = 0;
		visible = 1'b1;
		tick_count = 0;
		blink_period = BLINK_RESET;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_bytes_and_reads();
		test_blink_period();
		test_backpressure();
		test_random_traffic(450, 0, 0, 16'd50);
		test_random_traffic(450, 63, 0, 16'd1);
		test_random_traffic(450, 0, 63, 16'd65535);
		test_random_traffic(450, 7, 7, 16'd7);

		stall_pct = 0;
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("PASS text_console_char_grid");
		end else begin
			$display("FAIL text_console_char_grid");
		end
		$finish;
	end

endmodule

`default_nettype wire
